FILE: src/pdtc_pkg.sv
// Shared types, character constants and hex digit decode for the percent decoder.
`timescale 1ns / 1ps

package pdtc_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;
    localparam logic [7:0] CHAR_UA  = 8'h41;
    localparam logic [7:0] CHAR_UF  = 8'h46;
    localparam logic [7:0] CHAR_LA  = 8'h61;
    localparam logic [7:0] CHAR_LF  = 8'h66;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    localparam int unsigned NUM_RES = 3;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       traversal_flag;
    } out_item_t;

    // bit 4: valid hex digit, bits 3:0: digit value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] diff;
        logic [4:0] res;
        res  = 5'd0;
        diff = 8'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            diff = c - CHAR_0;
            res  = {1'b1, diff[3:0]};
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            diff = c - CHAR_UA + HEX_TEN;
            res  = {1'b1, diff[3:0]};
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            diff = c - CHAR_LA + HEX_TEN;
            res  = {1'b1, diff[3:0]};
        end
        return res;
    endfunction

endpackage

FILE: src/percent_decode_traversal_check.sv
// Lenient percent decoder with sticky dot-pair detection, top level.
// Path: an accepted request is registered in in_reg, then its results in res_reg, which drives m_.
// Throughput: one request per cycle while each request yields at most one result and m_ready
// stays high; a request that yields more than one result holds the decode stage while they drain.
// Reset: synchronous, active-low aresetn clears held state, flags and all valid bits.
`timescale 1ns / 1ps

module percent_decode_traversal_check (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pdtc_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pdtc_pkg::out_item_t   m_data
);

    pdtc_pkg::in_item_t  in_reg;
    logic                in_vld_reg, in_vld_next;

    logic [1:0]          held_count_reg, held_count_next;
    logic [7:0]          held_digit_reg, held_digit_next;
    logic                prev_was_dot_reg, prev_was_dot_next;
    logic                dots_seen_reg, dots_seen_next;

    pdtc_pkg::out_item_t res_reg [pdtc_pkg::NUM_RES];
    pdtc_pkg::out_item_t res_next [pdtc_pkg::NUM_RES];
    logic [1:0]          cnt_reg, cnt_next;
    logic [1:0]          rd_reg, rd_next;

    logic [2:0][7:0]     emit;
    logic [1:0]          emit_n;
    logic [4:0]          dig_b, dig_h;
    logic                advance, s_fire, m_fire;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = res_reg[rd_reg];
    assign m_fire  = m_valid && m_ready;
    assign advance = in_vld_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready));
    assign s_ready = !in_vld_reg || advance;
    assign s_fire  = s_valid && s_ready;
    assign in_vld_next = s_fire || (in_vld_reg && !advance);

    assign dig_b = pdtc_pkg::hex_digit(in_reg.in_byte);
    assign dig_h = pdtc_pkg::hex_digit(held_digit_reg);

    // build the list of bytes emitted by the held request
    always_comb begin
        emit            = '0;
        emit_n          = 2'd0;
        held_count_next = held_count_reg;
        held_digit_next = held_digit_reg;
        unique case (held_count_reg)
            pdtc_pkg::HELD_PCT: begin
                if (dig_b[4]) begin
                    if (in_reg.in_last) begin
                        emit[0] = pdtc_pkg::PCT_CHAR;
                        emit[1] = in_reg.in_byte;
                        emit_n  = 2'd2;
                    end else begin
                        held_count_next = pdtc_pkg::HELD_DIGIT;
                        held_digit_next = in_reg.in_byte;
                    end
                end else if (in_reg.in_byte == pdtc_pkg::PCT_CHAR) begin
                    emit[0] = pdtc_pkg::PCT_CHAR;
                    if (in_reg.in_last) begin
                        emit[1] = pdtc_pkg::PCT_CHAR;
                        emit_n  = 2'd2;
                    end else begin
                        emit_n          = 2'd1;
                        held_count_next = pdtc_pkg::HELD_PCT;
                    end
                end else begin
                    emit[0]         = pdtc_pkg::PCT_CHAR;
                    emit[1]         = in_reg.in_byte;
                    emit_n          = 2'd2;
                    held_count_next = pdtc_pkg::HELD_NONE;
                end
            end
            pdtc_pkg::HELD_DIGIT: begin
                if (dig_h[4] && dig_b[4]) begin
                    emit[0]         = {dig_h[3:0], dig_b[3:0]};
                    emit_n          = 2'd1;
                    held_count_next = pdtc_pkg::HELD_NONE;
                end else begin
                    emit[0] = pdtc_pkg::PCT_CHAR;
                    emit[1] = held_digit_reg;
                    if (in_reg.in_byte == pdtc_pkg::PCT_CHAR) begin
                        if (in_reg.in_last) begin
                            emit[2] = pdtc_pkg::PCT_CHAR;
                            emit_n  = 2'd3;
                        end else begin
                            emit_n          = 2'd2;
                            held_count_next = pdtc_pkg::HELD_PCT;
                        end
                    end else begin
                        emit[2]         = in_reg.in_byte;
                        emit_n          = 2'd3;
                        held_count_next = pdtc_pkg::HELD_NONE;
                    end
                end
            end
            default: begin
                if (in_reg.in_byte == pdtc_pkg::PCT_CHAR) begin
                    if (in_reg.in_last) begin
                        emit[0] = pdtc_pkg::PCT_CHAR;
                        emit_n  = 2'd1;
                    end else begin
                        held_count_next = pdtc_pkg::HELD_PCT;
                    end
                end else begin
                    emit[0]         = in_reg.in_byte;
                    emit_n          = 2'd1;
                    held_count_next = pdtc_pkg::HELD_NONE;
                end
            end
        endcase
        if (in_reg.in_last) begin
            held_count_next = pdtc_pkg::HELD_NONE;
            held_digit_next = 8'd0;
        end
    end

    // track dot pairs across the emitted bytes
    always_comb begin
        logic dot_prev;
        logic dot_seen;
        logic is_dot;
        dot_prev = prev_was_dot_reg;
        dot_seen = dots_seen_reg;
        is_dot   = 1'b0;
        for (int i = 0; i < pdtc_pkg::NUM_RES; i++) begin
            is_dot = (emit[i] == pdtc_pkg::DOT_CHAR);
            if (2'(i) < emit_n) begin
                if (is_dot && dot_prev) begin
                    dot_seen = 1'b1;
                end
                dot_prev = is_dot;
            end
            res_next[i].out_byte       = emit[i];
            res_next[i].traversal_flag = dot_seen;
            res_next[i].out_last       = in_reg.in_last && (2'(i) == (emit_n - 2'd1));
        end
        if (in_reg.in_last) begin
            dot_prev = 1'b0;
            dot_seen = 1'b0;
        end
        prev_was_dot_next = dot_prev;
        dots_seen_next    = dot_seen;
    end

    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (advance) begin
            cnt_next = emit_n;
            rd_next  = 2'd0;
        end else if (m_fire) begin
            cnt_next = cnt_reg - 2'd1;
            rd_next  = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg       <= 1'b0;
            cnt_reg          <= 2'd0;
            rd_reg           <= 2'd0;
            held_count_reg   <= pdtc_pkg::HELD_NONE;
            held_digit_reg   <= 8'd0;
            prev_was_dot_reg <= 1'b0;
            dots_seen_reg    <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
            cnt_reg    <= cnt_next;
            rd_reg     <= rd_next;
            if (advance) begin
                held_count_reg   <= held_count_next;
                held_digit_reg   <= held_digit_next;
                prev_was_dot_reg <= prev_was_dot_next;
                dots_seen_reg    <= dots_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_data;
        end
        if (advance) begin
            for (int i = 0; i < pdtc_pkg::NUM_RES; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

FILE: src/pdtc_checker.sv
// Port-level checker for the percent decoder, bound to the top level.
`timescale 1ns / 1ps

module pdtc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input pdtc_pkg::out_item_t m_data
);

    logic flag_held_reg;

    // hold the flag of the last delivered result of the current string
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_held_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            flag_held_reg <= m_data.out_last ? 1'b0 : m_data.traversal_flag;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && flag_held_reg |-> m_data.traversal_flag)
        else $error("traversal flag cleared inside a string");

    a_flag_on_dot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.traversal_flag && !flag_held_reg |->
            m_data.out_byte == pdtc_pkg::DOT_CHAR)
        else $error("traversal flag set on a byte that is not a dot");

endmodule

bind percent_decode_traversal_check pdtc_checker u_pdtc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the percent decoder with dot-pair detection.
`timescale 1ns / 1ps

module tb_top;

    class decode_scoreboard;
        logic [1:0]          held_count;
        logic [7:0]          held_digit;
        logic                prev_dot;
        logic                dots_seen;
        pdtc_pkg::out_item_t decoded_q[$];
        int                  errors;

        function new();
            held_count = pdtc_pkg::HELD_NONE;
            held_digit = 8'h00;
            prev_dot   = 1'b0;
            dots_seen  = 1'b0;
            errors     = 0;
        endfunction

        function int nibble_of(logic [7:0] c);
            if (c >= pdtc_pkg::CHAR_0 && c <= pdtc_pkg::CHAR_9)
                return int'(c - pdtc_pkg::CHAR_0);
            if (c >= pdtc_pkg::CHAR_UA && c <= pdtc_pkg::CHAR_UF)
                return int'(c - pdtc_pkg::CHAR_UA) + int'(pdtc_pkg::HEX_TEN);
            if (c >= pdtc_pkg::CHAR_LA && c <= pdtc_pkg::CHAR_LF)
                return int'(c - pdtc_pkg::CHAR_LA) + int'(pdtc_pkg::HEX_TEN);
            return -1;
        endfunction

        function void emit(logic [7:0] b);
            pdtc_pkg::out_item_t e;
            if (b == pdtc_pkg::DOT_CHAR && prev_dot) dots_seen = 1'b1;
            prev_dot         = (b == pdtc_pkg::DOT_CHAR);
            e.out_byte       = b;
            e.out_last       = 1'b0;
            e.traversal_flag = dots_seen;
            decoded_q        = {decoded_q, e};
        endfunction

        function void take_fresh(logic [7:0] b);
            if (b == pdtc_pkg::PCT_CHAR) begin
                held_count = pdtc_pkg::HELD_PCT;
            end else begin
                held_count = pdtc_pkg::HELD_NONE;
                emit(b);
            end
        endfunction

        function void note_request(pdtc_pkg::in_item_t req);
            int                  start_size;
            int                  hi;
            int                  lo;
            pdtc_pkg::out_item_t e;
            start_size = decoded_q.size();
            case (held_count)
                pdtc_pkg::HELD_PCT: begin
                    if (nibble_of(req.in_byte) >= 0) begin
                        held_digit = req.in_byte;
                        held_count = pdtc_pkg::HELD_DIGIT;
                    end else begin
                        emit(pdtc_pkg::PCT_CHAR);
                        take_fresh(req.in_byte);
                    end
                end
                pdtc_pkg::HELD_DIGIT: begin
                    hi = nibble_of(held_digit);
                    lo = nibble_of(req.in_byte);
                    if (hi >= 0 && lo >= 0) begin
                        held_count = pdtc_pkg::HELD_NONE;
                        emit(8'((hi << 4) | lo));
                    end else begin
                        emit(pdtc_pkg::PCT_CHAR);
                        emit(held_digit);
                        take_fresh(req.in_byte);
                    end
                end
                default: take_fresh(req.in_byte);
            endcase
            if (req.in_last) begin
                if (held_count == pdtc_pkg::HELD_PCT) begin
                    emit(pdtc_pkg::PCT_CHAR);
                end else if (held_count == pdtc_pkg::HELD_DIGIT) begin
                    emit(pdtc_pkg::PCT_CHAR);
                    emit(held_digit);
                end
                if (decoded_q.size() > start_size) begin
                    e = decoded_q[decoded_q.size() - 1];
                    e.out_last = 1'b1;
                    decoded_q[decoded_q.size() - 1] = e;
                end
                held_count = pdtc_pkg::HELD_NONE;
                held_digit = 8'h00;
                prev_dot   = 1'b0;
                dots_seen  = 1'b0;
            end
        endfunction

        function void check_result(pdtc_pkg::out_item_t got);
            pdtc_pkg::out_item_t want;
            if (decoded_q.size() == 0) begin
                $display("%0t ERROR unexpected result expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $display("%0t ERROR out_byte expected %02h actual %02h",
                         $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.out_last !== want.out_last) begin
                $display("%0t ERROR out_last expected %0b actual %0b",
                         $time, want.out_last, got.out_last);
                errors++;
            end
            if (got.traversal_flag !== want.traversal_flag) begin
                $display("%0t ERROR traversal_flag expected %0b actual %0b",
                         $time, want.traversal_flag, got.traversal_flag);
                errors++;
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    pdtc_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    pdtc_pkg::out_item_t m_data;

    decode_scoreboard sb = new();
    int         sent_count = 0;
    logic       calm = 1'b0;
    logic       hold_req = 1'b0;
    logic [7:0] path_q[$];

    always #1 aclk = ~aclk;

    percent_decode_traversal_check dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    task automatic send_request(input logic [7:0] b, input logic last);
        pdtc_pkg::in_item_t req;
        req.in_byte = b;
        req.in_last = last;
        while (!calm && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
        sent_count++;
    endtask

    task automatic send_path(input string p);
        for (int i = 0; i < p.len(); i++) send_request(p[i], i == p.len() - 1);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < pdtc_pkg::HEX_TEN[3:0]) return pdtc_pkg::CHAR_0 + 8'(v);
        return ($urandom_range(1) ? pdtc_pkg::CHAR_UA : pdtc_pkg::CHAR_LA) + 8'(v)
               - pdtc_pkg::HEX_TEN;
    endfunction

    task automatic build_path();
        int         tokens;
        int         pick;
        logic [7:0] v;
        path_q.delete();
        tokens = $urandom_range(6, 1);
        for (int t = 0; t < tokens; t++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                path_q = {path_q, 8'($urandom_range(8'h7E, 8'h20))};
            end else if (pick < 45) begin
                path_q = {path_q, pdtc_pkg::DOT_CHAR};
            end else if (pick < 75) begin
                v = ($urandom_range(2) == 0) ? pdtc_pkg::DOT_CHAR : 8'($urandom_range(255));
                path_q = {path_q, pdtc_pkg::PCT_CHAR};
                path_q = {path_q, hex_char(v[7:4])};
                path_q = {path_q, hex_char(v[3:0])};
            end else if (pick < 85) begin
                path_q = {path_q, pdtc_pkg::PCT_CHAR};
                if ($urandom_range(1)) path_q = {path_q, hex_char(4'($urandom_range(15)))};
                path_q = {path_q, 8'($urandom_range(255))};
            end else if (pick < 95) begin
                path_q = {path_q, 8'($urandom_range(255))};
            end else begin
                path_q = {path_q, pdtc_pkg::PCT_CHAR};
            end
        end
    endtask

    initial begin
        int  hold_left;
        bit  hold_done;
        logic ready_now;
        hold_left = 0;
        hold_done = 0;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                ready_now = 1'b0;
                hold_left--;
            end else begin
                ready_now = calm || ($urandom_range(99) >= 23);
            end
            m_ready <= ready_now;
            @(posedge aclk);
            if (m_valid === 1'b1 && ready_now) sb.check_result(m_data);
        end
    end

    initial begin
        int  guard;
        bit  paused;
        paused = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b1);
        send_path("%2e%2E");
        send_path("%aF");
        send_path("%4");
        send_path("%");
        send_path("%g.");
        send_path("%9z");
        send_path("%%30");

        while (sent_count < 460) begin
            if (sent_count >= 120) hold_req = 1'b1;
            calm = (sent_count >= 330 && sent_count < 410);
            if (sent_count >= 260 && !paused) begin
                paused = 1;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.pending() != 0) @(posedge aclk);
            end
            build_path();
            foreach (path_q[i]) send_request(path_q[i], i == path_q.size() - 1);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
